>>> hw/rtl/tbe_pkg.sv
// Package for the threshold blob extractor: shared constants, blob and run
// record types and the configuration bundle. No dependencies.
`default_nettype none
package tbe_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned MAX_BLOBS  = 64;

  localparam int unsigned CW   = 10;  // column and row width
  localparam int unsigned MW   = 21;  // mass width
  localparam int unsigned MXW  = 31;  // doubled x moment width
  localparam int unsigned MYW  = 30;  // y moment width
  localparam int unsigned RLW  = 11;  // run length width
  localparam int unsigned PXW  = 22;  // run x moment width
  localparam int unsigned PYW  = 21;  // run y moment width
  localparam int unsigned CFGW = 21;  // configuration data width
  localparam int unsigned CIW  = 3;   // configuration index width

  typedef enum logic [CIW-1:0] {
    REG_THRESHOLD  = 3'd0,
    REG_ASSOC      = 3'd1,
    REG_MIN_MASS   = 3'd2,
    REG_MAX_MASS   = 3'd3,
    REG_MIN_ASPECT = 3'd4,
    REG_MAX_ASPECT = 3'd5,
    REG_MIN_FILL   = 3'd6
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_SCAN,
    ST_EVAL1,
    ST_EVAL2,
    ST_EVAL3,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [CW-1:0]  x0;
    logic [CW-1:0]  x1;
    logic [CW-1:0]  y0;
    logic [CW-1:0]  y1;
    logic [MW-1:0]  mass;
    logic [MXW-1:0] mx;
    logic [MYW-1:0] my;
  } blob_t;

  typedef struct packed {
    logic           valid;
    logic [CW-1:0]  xa;
    logic [CW-1:0]  xb;
    logic [CW-1:0]  y;
    logic [CW:0]    cx2;
    logic [RLW-1:0] m;
    logic [PXW-1:0] pmx;
    logic [PYW-1:0] pmy;
  } run_t;

  typedef struct packed {
    logic [15:0] pixel_threshold;
    logic [7:0]  assoc_range;
    logic [20:0] min_mass;
    logic [20:0] max_mass;
    logic [17:0] min_aspect_q8;
    logic [17:0] max_aspect_q8;
    logic [8:0]  min_fill_q8;
  } cfg_t;

endpackage
`default_nettype wire

>>> hw/rtl/tbe_cell.sv
// One table cell of the blob chain: holds one blob, absorbs a passing run
// or forwards it, and shifts its blob towards the head during read-out.
// Depends on tbe_pkg.
`default_nettype none
module tbe_cell (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    shift_en,
  input  wire [7:0]              assoc_range,
  input  wire tbe_pkg::run_t     tok_in,
  output tbe_pkg::run_t          tok_out,
  input  wire                    right_occ,
  input  wire tbe_pkg::blob_t    right_blob,
  output logic                   occ,
  output tbe_pkg::blob_t         blob
);
  import tbe_pkg::*;

  logic          match;
  logic [CW+2:0] lo_l, lo_r, hi_l, hi_r;
  logic [CW+1:0] ylo_l, ylo_r, yhi_l, yhi_r;
  logic [MW:0]   mass_sum;
  logic [MXW:0]  mx_sum;
  logic [MYW:0]  my_sum;

  always_comb begin
    // Strict tests against the widened box, rearranged to stay unsigned.
    lo_l  = {2'b0, tok_in.cx2} + {4'b0, assoc_range, 1'b0};
    lo_r  = {2'b0, blob.x0, 1'b0};
    hi_l  = {2'b0, tok_in.cx2};
    hi_r  = ({3'b0, blob.x1} + {5'b0, assoc_range}) << 1;
    ylo_l = {2'b0, tok_in.y} + {4'b0, assoc_range};
    ylo_r = {2'b0, blob.y0};
    yhi_l = {2'b0, tok_in.y};
    yhi_r = {2'b0, blob.y1} + {4'b0, assoc_range};
    match = occ && (lo_l > lo_r) && (hi_l < hi_r) && (ylo_l > ylo_r) && (yhi_l < yhi_r);
    mass_sum = {1'b0, blob.mass} + {{(MW+1-RLW){1'b0}}, tok_in.m};
    mx_sum   = {1'b0, blob.mx} + {{(MXW+1-PXW){1'b0}}, tok_in.pmx};
    my_sum   = {1'b0, blob.my} + {{(MYW+1-PYW){1'b0}}, tok_in.pmy};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ           <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid && occ && !match;
      if (shift_en) begin
        occ <= right_occ;
      end else if (tok_in.valid && !occ) begin
        occ <= 1'b1;
      end
    end
    tok_out.xa  <= tok_in.xa;
    tok_out.xb  <= tok_in.xb;
    tok_out.y   <= tok_in.y;
    tok_out.cx2 <= tok_in.cx2;
    tok_out.m   <= tok_in.m;
    tok_out.pmx <= tok_in.pmx;
    tok_out.pmy <= tok_in.pmy;
    if (shift_en) begin
      blob <= right_blob;
    end else if (tok_in.valid && !occ) begin
      blob.x0   <= tok_in.xa;
      blob.x1   <= tok_in.xb;
      blob.y0   <= tok_in.y;
      blob.y1   <= tok_in.y;
      blob.mass <= {{(MW-RLW){1'b0}}, tok_in.m};
      blob.mx   <= {{(MXW-PXW){1'b0}}, tok_in.pmx};
      blob.my   <= {{(MYW-PYW){1'b0}}, tok_in.pmy};
    end else if (tok_in.valid && match) begin
      if (tok_in.xa < blob.x0) blob.x0 <= tok_in.xa;
      if (tok_in.xb > blob.x1) blob.x1 <= tok_in.xb;
      if (tok_in.y < blob.y0) blob.y0 <= tok_in.y;
      if (tok_in.y > blob.y1) blob.y1 <= tok_in.y;
      blob.mass <= mass_sum[MW] ? {MW{1'b1}} : mass_sum[MW-1:0];
      blob.mx   <= mx_sum[MXW] ? {MXW{1'b1}} : mx_sum[MXW-1:0];
      blob.my   <= my_sum[MYW] ? {MYW{1'b1}} : my_sum[MYW-1:0];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/tbe_filter.sv
// Two-stage limit check on one blob: mass, aspect and fill tests.
// Depends on tbe_pkg.
`default_nettype none
module tbe_filter (
  input  wire                  clk,
  input  wire tbe_pkg::cfg_t   cfg,
  input  wire tbe_pkg::blob_t  cand,
  output logic                 pass
);
  import tbe_pkg::*;

  logic [RLW-1:0]  w1, h1;
  logic [MW-1:0]   m1;
  logic [28:0]     pa1, pb1;
  logic [21:0]     wh1;
  logic [30:0]     fill2;
  logic [MW+7:0]   m256_2;
  logic            part2;
  logic [RLW+7:0]  h256;

  assign h256 = {h1, 8'b0};

  always_ff @(posedge clk) begin
    w1    <= {1'b0, cand.x1} - {1'b0, cand.x0} + RLW'(1);
    h1    <= {1'b0, cand.y1} - {1'b0, cand.y0} + RLW'(1);
    m1    <= cand.mass;
    pa1   <= 29'(cfg.min_aspect_q8) * 29'({1'b0, cand.x1} - {1'b0, cand.x0} + RLW'(1));
    pb1   <= 29'(cfg.max_aspect_q8) * 29'({1'b0, cand.x1} - {1'b0, cand.x0} + RLW'(1));
    wh1   <= 22'({1'b0, cand.x1} - {1'b0, cand.x0} + RLW'(1)) *
             22'({1'b0, cand.y1} - {1'b0, cand.y0} + RLW'(1));
    fill2  <= 31'(cfg.min_fill_q8) * 31'(wh1);
    m256_2 <= {m1, 8'b0};
    part2  <= (m1 >= cfg.min_mass) && (m1 <= cfg.max_mass) &&
              (29'(h256) >= pa1) && (29'(h256) <= pb1);
  end

  assign pass = part2 && (31'(m256_2) >= fill2);

endmodule
`default_nettype wire

>>> hw/rtl/threshold_blob_extractor.sv
// Top level of the threshold blob extractor: pixel front end, blob cell
// chain, limit filter and result register. Depends on tbe_pkg, tbe_cell and
// tbe_filter.
//
// Usage. Pixels enter in raster order on the in_valid/in_ready channel, one
// transaction per pixel, with row_end and frame_end marking row and frame
// ends. A pixel that does not close a run does not hold off the next. A pixel
// that closes a run hands the run to the head of a chain of MAX_BLOBS cells;
// it walks one cell per cycle until a cell absorbs it or it leaves the tail,
// and no pixel is taken while a run is in the chain. After a frame_end pixel
// the chain is read out from its head, one blob at a time through SCAN,
// EVAL1, EVAL2 and EVAL3 and the two-stage limit filter; kept blobs leave on
// the out_valid/out_ready channel, the last flagged by last_result, or a
// single invalid result if none passes. The result register holds a
// transaction until out_ready, and read-out waits only when it has a result
// to hand over while the register is full; new pixels are taken once read-out
// is done, even if the final result is still waiting. Configuration writes
// on cfg_write_en take effect at once; the user must make them only while the
// block is idle, which the block does not enforce. Synchronous reset empties
// the chain, clears the position counters and restores the register defaults.
`default_nettype none
module threshold_blob_extractor #(
  parameter int unsigned MAX_BLOBS = tbe_pkg::MAX_BLOBS
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      cfg_write_en,
  input  wire [tbe_pkg::CIW-1:0]   cfg_index,
  input  wire [tbe_pkg::CFGW-1:0]  cfg_data,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire [15:0]               pixel_value,
  input  wire                      row_end,
  input  wire                      frame_end,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic                     blob_valid,
  output logic [9:0]               box_min_x,
  output logic [9:0]               box_max_x,
  output logic [9:0]               box_min_y,
  output logic [9:0]               box_max_y,
  output logic [20:0]              blob_mass,
  output logic [30:0]              moment_x_doubled,
  output logic [29:0]              moment_y,
  output logic                     table_overflow,
  output logic                     last_result
);
  import tbe_pkg::*;

  // Configuration registers.
  cfg_t cfg;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_threshold <= 16'd32768;
      cfg.assoc_range     <= 8'd5;
      cfg.min_mass        <= 21'd1;
      cfg.max_mass        <= 21'd1048576;
      cfg.min_aspect_q8   <= 18'd64;
      cfg.max_aspect_q8   <= 18'd1024;
      cfg.min_fill_q8     <= 9'd0;
    end else if (cfg_write_en) begin
      unique case (reg_index_t'(cfg_index))
        REG_THRESHOLD:  cfg.pixel_threshold <= cfg_data[15:0];
        REG_ASSOC:      cfg.assoc_range     <= cfg_data[7:0];
        REG_MIN_MASS:   cfg.min_mass        <= cfg_data[20:0];
        REG_MAX_MASS:   cfg.max_mass        <= cfg_data[20:0];
        REG_MIN_ASPECT: cfg.min_aspect_q8   <= cfg_data[17:0];
        REG_MAX_ASPECT: cfg.max_aspect_q8   <= cfg_data[17:0];
        REG_MIN_FILL:   cfg.min_fill_q8     <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Front end: position counters and run detection.
  logic [CW-1:0] column_index, row_index, run_start;
  logic          in_run, overflow_seen;
  logic          accept, lit, rend, close_now;
  logic [CW-1:0] xa, xb;
  logic [CW:0]   cx2;
  logic [RLW-1:0] run_len;
  run_t          inj;
  state_t        state, state_next;
  logic          busy;

  assign accept = in_valid && in_ready;
  assign lit    = pixel_value > cfg.pixel_threshold;
  assign rend   = row_end || frame_end || (column_index == CW'(MAX_WIDTH - 1));

  always_comb begin
    // A run closes either on the first unlit pixel after it, or on a lit
    // pixel that ends the row; never both on one pixel.
    close_now = (in_run && !lit) || (lit && rend);
    xa        = (in_run) ? run_start : column_index;
    xb        = (in_run && !lit) ? (column_index - CW'(1)) : column_index;
    cx2       = {1'b0, xa} + {1'b0, xb};
    run_len   = {1'b0, xb} - {1'b0, xa} + RLW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      row_index    <= '0;
      in_run       <= 1'b0;
      run_start    <= '0;
      inj.valid    <= 1'b0;
    end else begin
      inj.valid <= accept && close_now;
      if (accept) begin
        if (frame_end) begin
          column_index <= '0;
          row_index    <= '0;
          in_run       <= 1'b0;
          run_start    <= '0;
        end else begin
          in_run <= lit && !rend;
          if (lit && !in_run) run_start <= column_index;
          if (rend) begin
            column_index <= '0;
            if (row_index != CW'(MAX_HEIGHT - 1)) row_index <= row_index + CW'(1);
          end else begin
            column_index <= column_index + CW'(1);
          end
        end
      end
    end
    inj.xa  <= xa;
    inj.xb  <= xb;
    inj.y   <= row_index;
    inj.cx2 <= cx2;
    inj.m   <= run_len;
    inj.pmx <= PXW'(run_len) * PXW'(cx2);
    inj.pmy <= PYW'(run_len) * PYW'(row_index);
  end

  // Cell chain. Runs travel from the head; read-out shifts towards the head.
  run_t        tok    [0:MAX_BLOBS];
  blob_t       blobs  [0:MAX_BLOBS-1];
  wire [MAX_BLOBS-1:0] occ;
  wire [MAX_BLOBS:0]   tok_live;
  logic        shift_en;

  assign tok[0] = inj;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_BLOBS; gi++) begin : g_cell
      logic  r_occ;
      blob_t r_blob;
      if (gi + 1 < MAX_BLOBS) begin : g_mid
        assign r_occ  = occ[gi+1];
        assign r_blob = blobs[gi+1];
      end else begin : g_end
        assign r_occ  = 1'b0;
        assign r_blob = '0;
      end
      tbe_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .shift_en    (shift_en),
        .assoc_range (cfg.assoc_range),
        .tok_in      (tok[gi]),
        .tok_out     (tok[gi+1]),
        .right_occ   (r_occ),
        .right_blob  (r_blob),
        .occ         (occ[gi]),
        .blob        (blobs[gi])
      );
    end
    for (gi = 0; gi <= MAX_BLOBS; gi++) begin : g_live
      assign tok_live[gi] = tok[gi].valid;
    end
  endgenerate

  assign busy = |tok_live;

  // Read-out: candidate register, limit filter and one pending kept blob, so
  // that the final kept blob can carry last_result.
  blob_t cand, pend;
  logic  have_pend, pass, out_free;
  logic  load_cand, emit_pend, emit_last, take_cand;

  tbe_filter u_filter (
    .clk  (clk),
    .cfg  (cfg),
    .cand (cand),
    .pass (pass)
  );

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    shift_en   = 1'b0;
    load_cand  = 1'b0;
    emit_pend  = 1'b0;
    emit_last  = 1'b0;
    take_cand  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !busy;
        if (accept && frame_end) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!busy) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (occ[0]) begin
          load_cand  = 1'b1;
          shift_en   = 1'b1;
          state_next = ST_EVAL1;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_EVAL1: state_next = ST_EVAL2;
      ST_EVAL2: state_next = ST_EVAL3;
      ST_EVAL3: begin
        if (!pass) begin
          state_next = ST_SCAN;
        end else if (!have_pend) begin
          take_cand  = 1'b1;
          state_next = ST_SCAN;
        end else if (out_free) begin
          emit_pend  = 1'b1;
          take_cand  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          emit_last  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_pend     <= 1'b0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // A run leaving the tail found neither a match nor a free cell.
      if (tok[MAX_BLOBS].valid) overflow_seen <= 1'b1;
      if (take_cand) have_pend <= 1'b1;
      if (emit_last) begin
        have_pend     <= 1'b0;
        overflow_seen <= 1'b0;
      end
      if (emit_pend || emit_last) out_valid <= 1'b1;
      else if (out_ready)         out_valid <= 1'b0;
    end
    if (load_cand) cand <= blobs[0];
    if (take_cand) pend <= cand;
    if (emit_pend || emit_last) begin
      blob_valid       <= have_pend;
      box_min_x        <= have_pend ? pend.x0 : '0;
      box_max_x        <= have_pend ? pend.x1 : '0;
      box_min_y        <= have_pend ? pend.y0 : '0;
      box_max_y        <= have_pend ? pend.y1 : '0;
      blob_mass        <= have_pend ? pend.mass : '0;
      moment_x_doubled <= have_pend ? pend.mx : '0;
      moment_y         <= have_pend ? pend.my : '0;
      table_overflow   <= overflow_seen;
      last_result      <= emit_last;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/tbe_checker.sv
// Port-level checker for the threshold blob extractor and its bind.
// Depends on the top level's ports only.
`default_nettype none
module tbe_checker (
  input wire        clk,
  input wire        rst,
  input wire        out_valid,
  input wire        out_ready,
  input wire        blob_valid,
  input wire [9:0]  box_min_x,
  input wire [9:0]  box_max_x,
  input wire [9:0]  box_min_y,
  input wire [9:0]  box_max_y,
  input wire [20:0] blob_mass,
  input wire [30:0] moment_x_doubled,
  input wire [29:0] moment_y,
  input wire        last_result
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(blob_mass) && $stable(last_result))
    else $error("result changed while stalled");

  a_empty_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && !blob_valid |-> last_result && blob_mass == 21'd0 &&
      moment_x_doubled == 31'd0 && moment_y == 30'd0 && box_max_x == 10'd0)
    else $error("invalid result not empty or not last");

  a_box_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && blob_valid |-> box_min_x <= box_max_x && box_min_y <= box_max_y)
    else $error("box corners out of order");

  a_mass_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && blob_valid |-> blob_mass != 21'd0)
    else $error("kept blob without mass");

endmodule

bind threshold_blob_extractor tbe_checker u_tbe_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .blob_valid       (blob_valid),
  .box_min_x        (box_min_x),
  .box_max_x        (box_max_x),
  .box_min_y        (box_min_y),
  .box_max_y        (box_max_y),
  .blob_mass        (blob_mass),
  .moment_x_doubled (moment_x_doubled),
  .moment_y         (moment_y),
  .last_result      (last_result)
);
`default_nettype wire
